@@ src/aff2d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_pkg
// Shared types, widths and the CORDIC arctangent table for the 2D affine
// point transform.
// ----------------------------------------------------------------------------
package aff2d_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int ANGLE_BITS_DEF  = 16;

	localparam int LIN_W  = 25;  // linear matrix terms, Q9.16
	localparam int TRIG_W = 18;  // sine and cosine, Q2.16 in [-1, 1]
	localparam int PROD_W = 57;  // coordinate times linear term
	localparam int SUM_W  = 59;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W = 5;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STR_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STR_Y   = 3'd5;

	localparam logic [2:0] ORD_RST = 3'd0;
	localparam logic [2:0] ORD_RTS = 3'd1;
	localparam logic [2:0] ORD_SRT = 3'd2;
	localparam logic [2:0] ORD_STR = 3'd3;
	localparam logic [2:0] ORD_TRS = 3'd4;
	localparam logic [2:0] ORD_TSR = 3'd5;

	typedef struct packed {
		logic [2:0]         order;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic [15:0]        angle;
		logic signed [15:0] stretch_x;
		logic signed [15:0] stretch_y;
	} cfg_t;

	typedef struct packed {
		logic signed [LIN_W-1:0] a;
		logic signed [LIN_W-1:0] b;
		logic signed [LIN_W-1:0] c;
		logic signed [LIN_W-1:0] d;
		logic signed [31:0]      tx;
		logic signed [31:0]      ty;
	} matrix_t;

	typedef enum logic [4:0] {
		ST_START  = 5'b00001,
		ST_ANGLE  = 5'b00010,
		ST_FINISH = 5'b00100,
		ST_TERMS  = 5'b01000,
		ST_READY  = 5'b10000
	} build_state_t;

	function automatic logic signed [33:0] atan_phase(input logic [STEP_W-1:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:  r = 34'sh20000000;
			5'd1:  r = 34'sh12E4051E;
			5'd2:  r = 34'sh09FB385B;
			5'd3:  r = 34'sh051111D4;
			5'd4:  r = 34'sh028B0D43;
			5'd5:  r = 34'sh0145D7E1;
			5'd6:  r = 34'sh00A2F61E;
			5'd7:  r = 34'sh00517C55;
			5'd8:  r = 34'sh0028BE53;
			5'd9:  r = 34'sh00145F2F;
			5'd10: r = 34'sh000A2F98;
			5'd11: r = 34'sh000517CC;
			5'd12: r = 34'sh00028BE6;
			5'd13: r = 34'sh000145F3;
			5'd14: r = 34'sh0000A2FA;
			5'd15: r = 34'sh0000517D;
			5'd16: r = 34'sh000028BE;
			5'd17: r = 34'sh0000145F;
			5'd18: r = 34'sh00000A30;
			5'd19: r = 34'sh00000518;
			5'd20: r = 34'sh0000028C;
			5'd21: r = 34'sh00000146;
			5'd22: r = 34'sh000000A3;
			5'd23: r = 34'sh00000051;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > 59'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -59'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/affine_point_transform_2d.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_point_transform_2d
// Maps Q16.16 points through a configured rotation, scale and translation.
// ----------------------------------------------------------------------------
// Points flow through a four-stage pipeline (input register, four multiplies,
// sum with translation, round and saturate) at one point per clock when
// neither out_stall nor a matrix rebuild holds them. A write to any of the
// six registers rebuilds the matrix: a start step, 24 CORDIC iterations, a
// finish step and 9 multiply steps, during which in_stall stays high.
// The same rebuild runs after reset.
// ----------------------------------------------------------------------------
module affine_point_transform_2d #(
	parameter int COORD_WIDTH = aff2d_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_BITS  = aff2d_pkg::ANGLE_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire signed [31:0]   point_x,
	input  wire signed [31:0]   point_y,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic signed [31:0]  mapped_x,
	output logic signed [31:0]  mapped_y,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [aff2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [31:0]          cfg_data
);

	localparam int SAT = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int RW  = aff2d_pkg::SUM_W - 16;
	localparam logic signed [RW-1:0] HI = (RW'(1) <<< (SAT - 1)) - RW'(1);
	localparam logic signed [RW-1:0] LO = -HI - RW'(1);

	aff2d_pkg::cfg_t    cfg_q;
	aff2d_pkg::matrix_t mat;
	logic mat_ready, cfg_wr;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;
	logic signed [31:0] x_s1, y_s1;
	logic signed [aff2d_pkg::PROD_W-1:0] ax_s2, by_s2, cx_s2, dy_s2;
	logic signed [31:0] tx_s2, ty_s2;
	logic signed [aff2d_pkg::SUM_W-1:0] sx_s3, sy_s3;
	logic signed [aff2d_pkg::SUM_W-1:0] rsx, rsy;
	logic signed [RW-1:0] rx, ry;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && (cfg_index <= aff2d_pkg::REG_STR_Y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order     <= aff2d_pkg::ORD_RST;
			cfg_q.shift_x   <= 32'sd0;
			cfg_q.shift_y   <= 32'sd0;
			cfg_q.angle     <= 16'd0;
			cfg_q.stretch_x <= 16'sd256;
			cfg_q.stretch_y <= 16'sd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				aff2d_pkg::REG_ORDER:   cfg_q.order     <= cfg_data[2:0];
				aff2d_pkg::REG_SHIFT_X: cfg_q.shift_x   <= cfg_data;
				aff2d_pkg::REG_SHIFT_Y: cfg_q.shift_y   <= cfg_data;
				aff2d_pkg::REG_ANGLE:   cfg_q.angle     <= cfg_data[15:0];
				aff2d_pkg::REG_STR_X:   cfg_q.stretch_x <= cfg_data[15:0];
				aff2d_pkg::REG_STR_Y:   cfg_q.stretch_y <= cfg_data[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	aff2d_matrix #(.ANGLE_BITS(ANGLE_BITS)) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.cfg     (cfg_q),
		.ready   (mat_ready),
		.mat     (mat)
	);

	// Each stage moves on when it is empty or the stage after it moves.
	assign adv4 = !v_s4 || !out_stall;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1 || !mat_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid && mat_ready;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	assign rsx = (sx_s3 + 59'sd32768) >>> 16;
	assign rsy = (sy_s3 + 59'sd32768) >>> 16;
	assign rx  = rsx[RW-1:0];
	assign ry  = rsy[RW-1:0];

	always_ff @(posedge clk) begin
		if (adv1 && in_valid && mat_ready) begin
			x_s1 <= 32'(signed'(point_x[SAT-1:0]));
			y_s1 <= 32'(signed'(point_y[SAT-1:0]));
		end
		if (adv2 && v_s1) begin
			ax_s2 <= 57'(mat.a * x_s1);
			by_s2 <= 57'(mat.b * y_s1);
			cx_s2 <= 57'(mat.c * x_s1);
			dy_s2 <= 57'(mat.d * y_s1);
			tx_s2 <= mat.tx;
			ty_s2 <= mat.ty;
		end
		if (adv3 && v_s2) begin
			sx_s3 <= 59'(ax_s2) + 59'(by_s2) + (59'(tx_s2) <<< 16);
			sy_s3 <= 59'(cx_s2) + 59'(dy_s2) + (59'(ty_s2) <<< 16);
		end
		if (adv4 && v_s3) begin
			mapped_x <= (rx > HI) ? 32'(HI) : (rx < LO) ? 32'(LO) : rx[31:0];
			mapped_y <= (ry > HI) ? 32'(HI) : (ry < LO) ? 32'(LO) : ry[31:0];
		end
	end

	assign out_valid = v_s4;

endmodule
`default_nettype wire

@@ src/aff2d_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_matrix
// Rebuilds the cached 2x3 matrix: a 24-step CORDIC for sine and cosine, then
// eight products on one shared multiplier for the linear and shift terms.
// ----------------------------------------------------------------------------
module aff2d_matrix #(
	parameter int ANGLE_BITS = aff2d_pkg::ANGLE_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  restart,
	input  aff2d_pkg::cfg_t      cfg,
	output logic                 ready,
	output aff2d_pkg::matrix_t   mat
);

	aff2d_pkg::build_state_t state_q;
	logic [aff2d_pkg::STEP_W-1:0] iter_q;
	logic [3:0]                   cnt_q;
	logic signed [33:0]           cx_q, cy_q, cz_q;
	logic                         flip_q;
	logic signed [aff2d_pkg::TRIG_W-1:0] cos_q, sin_q;
	logic signed [aff2d_pkg::PROD_W-1:0] prod_q;
	logic signed [aff2d_pkg::SUM_W-1:0]  acc_q;
	aff2d_pkg::matrix_t mat_q;

	logic [2:0]  ord;
	logic [31:0] phase, phase_adj;
	logic        flip;
	logic signed [33:0] xs, ys, ang;
	logic signed [33:0] fx, fy;
	logic signed [19:0] rx, ry;
	logic signed [31:0] ma;
	logic signed [aff2d_pkg::LIN_W-1:0] mb;
	logic signed [aff2d_pkg::SUM_W-1:0] prod_ext, sum, rnd8, rnd16;
	logic swap;

	assign ord  = (cfg.order > aff2d_pkg::ORD_TSR) ? aff2d_pkg::ORD_RST : cfg.order;
	assign swap = (ord == aff2d_pkg::ORD_SRT) || (ord == aff2d_pkg::ORD_STR)
		|| (ord == aff2d_pkg::ORD_TSR);

	// The low ANGLE_BITS bits of the angle sit at the top of the 32-bit phase.
	assign phase     = {16'd0, cfg.angle} << (32 - ANGLE_BITS);
	assign flip      = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
	assign phase_adj = flip ? (phase - 32'h80000000) : phase;

	assign xs  = cx_q >>> iter_q;
	assign ys  = cy_q >>> iter_q;
	assign ang = aff2d_pkg::atan_phase(iter_q);

	assign fx = flip_q ? -cx_q : cx_q;
	assign fy = flip_q ? -cy_q : cy_q;
	assign rx = 20'((fx + 34'sd8192) >>> 14);
	assign ry = 20'((fy + 34'sd8192) >>> 14);

	// Operand selection for the shared multiplier, one product per step.
	always_comb begin
		ma = 32'sd0;
		mb = '0;
		case (cnt_q)
			4'd0: begin ma = 32'(cfg.stretch_x); mb = 25'(cos_q); end
			4'd1: begin ma = 32'(cfg.stretch_y); mb = 25'(cos_q); end
			4'd2: begin ma = swap ? 32'(cfg.stretch_y) : 32'(cfg.stretch_x); mb = 25'(sin_q); end
			4'd3: begin ma = swap ? 32'(cfg.stretch_x) : 32'(cfg.stretch_y); mb = 25'(sin_q); end
			4'd4: begin
				ma = cfg.shift_x;
				if (ord == aff2d_pkg::ORD_RTS) mb = 25'(cfg.stretch_x);
				else if (ord == aff2d_pkg::ORD_STR) mb = 25'(cos_q);
				else mb = mat_q.a;
			end
			4'd5: begin
				ma = cfg.shift_y;
				if (ord == aff2d_pkg::ORD_RTS) mb = '0;
				else if (ord == aff2d_pkg::ORD_STR) mb = -25'(sin_q);
				else mb = mat_q.b;
			end
			4'd6: begin
				if (ord == aff2d_pkg::ORD_RTS) begin
					ma = cfg.shift_y; mb = 25'(cfg.stretch_y);
				end else if (ord == aff2d_pkg::ORD_STR) begin
					ma = cfg.shift_x; mb = 25'(sin_q);
				end else begin
					ma = cfg.shift_x; mb = mat_q.c;
				end
			end
			4'd7: begin
				ma = cfg.shift_y;
				if (ord == aff2d_pkg::ORD_RTS) mb = '0;
				else if (ord == aff2d_pkg::ORD_STR) mb = 25'(cos_q);
				else mb = mat_q.d;
			end
			default: begin ma = 32'sd0; mb = '0; end
		endcase
	end

	assign prod_ext = 59'(prod_q);
	assign sum      = acc_q + prod_ext;
	assign rnd8     = (prod_ext + 59'sd128) >>> 8;
	assign rnd16    = (sum + 59'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aff2d_pkg::ST_START;
			iter_q  <= '0;
			cnt_q   <= '0;
		end else if (restart) begin
			state_q <= aff2d_pkg::ST_START;
		end else begin
			case (state_q)
				aff2d_pkg::ST_START: begin
					iter_q  <= '0;
					state_q <= aff2d_pkg::ST_ANGLE;
				end
				aff2d_pkg::ST_ANGLE: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == 5'(aff2d_pkg::CORDIC_STEPS - 1)) begin
						state_q <= aff2d_pkg::ST_FINISH;
					end
				end
				aff2d_pkg::ST_FINISH: begin
					cnt_q   <= '0;
					state_q <= aff2d_pkg::ST_TERMS;
				end
				aff2d_pkg::ST_TERMS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd8) begin
						state_q <= aff2d_pkg::ST_READY;
					end
				end
				aff2d_pkg::ST_READY: state_q <= aff2d_pkg::ST_READY;
				default: state_q <= aff2d_pkg::ST_START;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			aff2d_pkg::ST_START: begin
				cx_q   <= aff2d_pkg::CORDIC_GAIN;
				cy_q   <= 34'sd0;
				cz_q   <= 34'(signed'(phase_adj));
				flip_q <= flip;
			end
			aff2d_pkg::ST_ANGLE: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - ang;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + ang;
				end
			end
			aff2d_pkg::ST_FINISH: begin
				cos_q <= (rx > 20'sd65536) ? 18'sd65536 :
					(rx < -20'sd65536) ? -18'sd65536 : rx[17:0];
				sin_q <= (ry > 20'sd65536) ? 18'sd65536 :
					(ry < -20'sd65536) ? -18'sd65536 : ry[17:0];
			end
			aff2d_pkg::ST_TERMS: begin
				prod_q <= 57'(ma * mb);
				// The product of the previous step lands here.
				case (cnt_q)
					4'd1: mat_q.a <= rnd8[aff2d_pkg::LIN_W-1:0];
					4'd2: mat_q.d <= rnd8[aff2d_pkg::LIN_W-1:0];
					4'd3: mat_q.b <= -rnd8[aff2d_pkg::LIN_W-1:0];
					4'd4: mat_q.c <= rnd8[aff2d_pkg::LIN_W-1:0];
					4'd5, 4'd7: acc_q <= prod_ext;
					4'd6: begin
						if (ord == aff2d_pkg::ORD_RTS)
							mat_q.tx <= aff2d_pkg::sat32((acc_q + 59'sd128) >>> 8);
						else if (ord == aff2d_pkg::ORD_STR || ord == aff2d_pkg::ORD_TRS
							|| ord == aff2d_pkg::ORD_TSR)
							mat_q.tx <= aff2d_pkg::sat32(rnd16);
						else
							mat_q.tx <= cfg.shift_x;
					end
					4'd8: begin
						if (ord == aff2d_pkg::ORD_RTS)
							mat_q.ty <= aff2d_pkg::sat32((acc_q + 59'sd128) >>> 8);
						else if (ord == aff2d_pkg::ORD_STR || ord == aff2d_pkg::ORD_TRS
							|| ord == aff2d_pkg::ORD_TSR)
							mat_q.ty <= aff2d_pkg::sat32(rnd16);
						else
							mat_q.ty <= cfg.shift_y;
					end
					default: acc_q <= acc_q;
				endcase
			end
			default: prod_q <= prod_q;
		endcase
	end

	assign ready = (state_q == aff2d_pkg::ST_READY);
	assign mat   = mat_q;

endmodule
`default_nettype wire

@@ src/aff2d_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_checker
// Port-level checks for the affine point transform, bound to the top level.
// ----------------------------------------------------------------------------
module aff2d_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [31:0] mapped_x,
	input wire [31:0] mapped_y,
	input wire        cfg_valid,
	input wire        cfg_ready,
	input wire [2:0]  cfg_index
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mapped_x) && $stable(mapped_y))
		else $error("stalled result changed");

	// A register write triggers a matrix rebuild that blocks new requests.
	a_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index <= aff2d_pkg::REG_STR_Y |=> in_stall)
		else $error("request taken during matrix rebuild");

	// With no back-pressure an accepted request shows up at the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
		##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind affine_point_transform_2d aff2d_checker u_aff2d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.mapped_x  (mapped_x),
	.mapped_y  (mapped_y),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);
`default_nettype wire
